### rtl/world_to_screen_projection_top_assert.svh
// Assertion macros shared by the projection pipeline.
`ifndef WORLD_TO_SCREEN_PROJECTION_TOP_ASSERT_SVH
`define WORLD_TO_SCREEN_PROJECTION_TOP_ASSERT_SVH

// Implication checked on every rising clock edge, disabled while reset is asserted.
`define WSP_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define WSP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/wsp_pkg.sv
package wsp_pkg;

	localparam int unsigned WORD_W  = 32;
	localparam int unsigned ENTRIES = 16;
	localparam int unsigned IDX_W   = 4;
	localparam int unsigned CLIP_W  = 66;

	typedef enum logic [1:0] {
		MODE_NONE = 2'd0,
		MODE_ROW  = 2'd1,
		MODE_COL  = 2'd2,
		MODE_RSVD = 2'd3
	} mode_t;

	localparam logic [1:0] REG_MODE   = 2'd0;
	localparam logic [1:0] REG_WIDTH  = 2'd1;
	localparam logic [1:0] REG_HEIGHT = 2'd2;

	localparam logic CMD_LOAD    = 1'b0;
	localparam logic CMD_PROJECT = 1'b1;

	// Per-stage pipeline control bundle.
	typedef struct packed {
		logic valid;
		logic live;
	} stage_ctl_t;

endpackage

### rtl/wsp_if.sv
interface wsp_in_if;
	logic               valid;
	logic               ready;
	logic               command;
	logic [3:0]         entry_index;
	logic signed [31:0] entry_value;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic signed [31:0] pos_z;

	modport source (output valid, command, entry_index, entry_value, pos_x, pos_y, pos_z,
		input ready);
	modport sink (input valid, command, entry_index, entry_value, pos_x, pos_y, pos_z,
		output ready);
endinterface

interface wsp_out_if;
	logic               valid;
	logic               ready;
	logic               visible;
	logic signed [31:0] screen_x;
	logic signed [31:0] screen_y;

	modport source (output valid, visible, screen_x, screen_y, input ready);
	modport sink (input valid, visible, screen_x, screen_y, output ready);
endinterface

### rtl/wsp_divider.sv
// Pipelined restoring divider: q = trunc(num * 2^FB / den), saturated to 32 bits.
// One quotient bit per stage over QB stages; den is positive.
module wsp_divider #(
	parameter int unsigned FB = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                adv,
	input  logic signed [65:0]  num,
	input  logic signed [65:0]  den,
	output logic signed [31:0]  quo
);
	localparam int unsigned QB = 34;
	localparam int unsigned MW = 66 + FB;

	logic [MW-1:0] rem_s [QB+1];
	logic [MW-1:0] dd_s  [QB+1];
	logic [QB-1:0] q_s   [QB+1];
	logic          neg_s [QB+1];
	logic          ovf_s [QB+1];
	logic [MW-1:0] rem_n [QB];
	logic [QB-1:0] q_n   [QB];
	logic [MW-1:0] mag;
	logic [MW-1:0] dz;

	always_comb begin
		mag = num[65] ? MW'(-num) : MW'(num);
		mag = mag << FB;
		dz  = MW'(den);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rem_s[0] <= mag;
			dd_s[0]  <= dz;
			q_s[0]   <= '0;
			neg_s[0] <= num[65];
			// Any magnitude whose quotient exceeds QB bits is saturated.
			ovf_s[0] <= ((mag >> QB) >= dz);
		end
	end

	for (genvar g = 0; g < QB; g++) begin : g_step
		localparam int unsigned SH = QB - 1 - g;
		logic [MW-1:0] sub;
		always_comb begin
			sub = dd_s[g] << SH;
			if ((rem_s[g] >> SH) >= dd_s[g]) begin
				rem_n[g] = rem_s[g] - sub;
				q_n[g]   = q_s[g] | (QB'(1) << SH);
			end else begin
				rem_n[g] = rem_s[g];
				q_n[g]   = q_s[g];
			end
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				rem_s[g+1] <= rem_n[g];
				q_s[g+1]   <= q_n[g];
				dd_s[g+1]  <= dd_s[g];
				neg_s[g+1] <= neg_s[g];
				ovf_s[g+1] <= ovf_s[g];
			end
		end
	end

	always_comb begin
		if (neg_s[QB]) begin
			if (ovf_s[QB] || q_s[QB] > QB'(33'h080000000))
				quo = 32'sh80000000;
			else
				quo = 32'(-$signed({1'b0, q_s[QB]}));
		end else begin
			if (ovf_s[QB] || q_s[QB] > QB'(32'h7FFFFFFF))
				quo = 32'sh7FFFFFFF;
			else
				quo = 32'(q_s[QB]);
		end
	end

	logic unused;
	assign unused = arst_n ^ (|rem_s[QB]);
endmodule

### rtl/wsp_transform.sv
// Matrix store and the clip-space multiply-accumulate stages.
module wsp_transform #(
	parameter int unsigned FB = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               adv,
	input  logic               load,
	input  logic [3:0]         load_idx,
	input  logic signed [31:0] load_val,
	input  logic [1:0]         mode,
	input  logic signed [31:0] px,
	input  logic signed [31:0] py,
	input  logic signed [31:0] pz,
	output logic signed [65:0] cx,
	output logic signed [65:0] cy,
	output logic signed [65:0] cw
);
	logic signed [31:0] mat_q [wsp_pkg::ENTRIES];
	logic signed [31:0] coef  [3][4];
	logic signed [31:0] coef_s1 [3][4];
	logic signed [31:0] px_s1, py_s1, pz_s1;
	logic signed [63:0] prod_s2 [3][3];
	logic signed [31:0] off_s2 [3];
	logic signed [65:0] sum [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < wsp_pkg::ENTRIES; i++) mat_q[i] <= '0;
		end else if (load) begin
			mat_q[load_idx] <= load_val;
		end
	end

	// Row-major rows 0,1,3 or column-major columns 0,1,3.
	always_comb begin
		for (int r = 0; r < 3; r++) begin
			for (int k = 0; k < 4; k++) begin
				if (mode == wsp_pkg::MODE_COL)
					coef[r][k] = mat_q[4*k + (r == 2 ? 3 : r)];
				else
					coef[r][k] = mat_q[4*(r == 2 ? 3 : r) + k];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			coef_s1 <= coef;
			px_s1 <= px;
			py_s1 <= py;
			pz_s1 <= pz;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int r = 0; r < 3; r++) begin
				prod_s2[r][0] <= px_s1 * coef_s1[r][0];
				prod_s2[r][1] <= py_s1 * coef_s1[r][1];
				prod_s2[r][2] <= pz_s1 * coef_s1[r][2];
				off_s2[r]     <= coef_s1[r][3];
			end
		end
	end

	// Arithmetic shift floors each product.
	always_comb begin
		for (int r = 0; r < 3; r++) begin
			sum[r] = 66'(prod_s2[r][0] >>> FB) + 66'(prod_s2[r][1] >>> FB)
				+ 66'(prod_s2[r][2] >>> FB) + 66'(off_s2[r]);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cx <= sum[0];
			cy <= sum[1];
			cw <= sum[2];
		end
	end
endmodule

### rtl/world_to_screen_projection_top.sv
// Perspective projection with viewport mapping. A load transfer (command 0)
// writes one entry of the 4x4 Q16.16 matrix and produces no result; a point
// transfer (command 1) produces one result with visible, screen_x and
// screen_y. The block accepts one transfer per cycle while the output is
// not stalled. A point result passes through registered stages for matrix
// select, multiply and clip sums, the visibility test, the divider stages
// (one quotient bit per stage), then the viewport stage. The whole
// pipeline advances together and stalls only when the output register is
// full and not taken, so nothing is lost or repeated. Configuration writes
// should occur only while the pipeline is empty.
module world_to_screen_projection_top #(
	parameter int unsigned FRAC_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	wsp_in_if.sink      in_ch,
	wsp_out_if.source   out_ch
);
	localparam int unsigned QB    = 34;
	localparam int unsigned DEPTH = 3 + 1 + QB;
	localparam logic signed [65:0] THRESH = 66'(((64'd1 << FRAC_BITS) + 5) / 10);

	logic [1:0]  mode_q;
	logic [15:0] width_q, height_q;
	logic        adv, in_xfer, load;
	wsp_pkg::stage_ctl_t ctl_q [DEPTH];
	logic signed [65:0] cx, cy, cw;
	logic signed [31:0] nx, ny;
	logic        vis_s4;
	logic [QB:0] vis_line_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= '0;
			width_q  <= '0;
			height_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				wsp_pkg::REG_MODE:   mode_q   <= cfg_data[1:0];
				wsp_pkg::REG_WIDTH:  width_q  <= cfg_data;
				wsp_pkg::REG_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// The output register is the only place a result can wait.
	assign adv         = !out_ch.valid || out_ch.ready;
	assign in_ch.ready = adv;
	assign in_xfer     = in_ch.valid && adv;
	assign load        = in_xfer && in_ch.command == wsp_pkg::CMD_LOAD;

	wsp_transform #(.FB(FRAC_BITS)) u_xf (
		.clk, .arst_n, .adv, .load,
		.load_idx(in_ch.entry_index), .load_val(in_ch.entry_value),
		.mode(mode_q), .px(in_ch.pos_x), .py(in_ch.pos_y), .pz(in_ch.pos_z),
		.cx, .cy, .cw
	);

	// Stage valid bits; live marks a point whose mode is supported.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++) ctl_q[i] <= '0;
		end else if (adv) begin
			ctl_q[0].valid <= in_xfer && in_ch.command == wsp_pkg::CMD_PROJECT;
			ctl_q[0].live  <= mode_q == wsp_pkg::MODE_ROW || mode_q == wsp_pkg::MODE_COL;
			for (int i = 1; i < DEPTH; i++) ctl_q[i] <= ctl_q[i-1];
		end
	end

	// Visibility is known once cw is out; non-visible points divide by one.
	logic signed [65:0] den;
	always_comb begin
		vis_s4 = ctl_q[2].live && !(cw < THRESH);
		den    = vis_s4 ? cw : 66'sd1;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			vis_line_q <= {vis_line_q[QB-1:0], vis_s4};
		end
	end

	wsp_divider #(.FB(FRAC_BITS)) u_dx (.clk, .arst_n, .adv, .num(cx), .den, .quo(nx));
	wsp_divider #(.FB(FRAC_BITS)) u_dy (.clk, .arst_n, .adv, .num(cy), .den, .quo(ny));

	logic        vis_q;
	logic [15:0] hw, hh;
	logic signed [66:0] sx_w, sy_w;
	logic signed [31:0] sx, sy;
	logic        vis_d;

	always_comb begin
		vis_d = vis_line_q[QB];
		hw    = width_q >> 1;
		hh    = height_q >> 1;
		sx_w  = 67'($signed({1'b0, hw})) * 67'(nx) + (67'(hw) <<< FRAC_BITS);
		sy_w  = (67'(hh) <<< FRAC_BITS) - 67'($signed({1'b0, hh})) * 67'(ny);
		if (sx_w > 67'sh7FFFFFFF) sx = 32'sh7FFFFFFF;
		else if (sx_w < -67'sh80000000) sx = 32'sh80000000;
		else sx = 32'(sx_w);
		if (sy_w > 67'sh7FFFFFFF) sy = 32'sh7FFFFFFF;
		else if (sy_w < -67'sh80000000) sy = 32'sh80000000;
		else sy = 32'(sy_w);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.valid <= 1'b0;
		end else if (adv) begin
			out_ch.valid <= ctl_q[DEPTH-1].valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			vis_q           <= vis_d;
			out_ch.visible  <= vis_d;
			out_ch.screen_x <= vis_d ? sx : '0;
			out_ch.screen_y <= vis_d ? sy : '0;
		end
	end

`include "world_to_screen_projection_top_assert.svh"

	`WSP_ASSERT_IMPL(a_ready_follows, clk, arst_n, out_ch.valid && !out_ch.ready, !in_ch.ready, "input ready while output stalled")
	`WSP_ASSERT_IMPL(a_vis_zero, clk, arst_n, out_ch.valid && !out_ch.visible, out_ch.screen_x == 0 && out_ch.screen_y == 0, "invisible result carries coordinates")
	`WSP_ASSERT_NEXT(a_hold, clk, arst_n, out_ch.valid && !out_ch.ready, out_ch.valid && $stable(vis_q), "stalled result changed")
endmodule
